### hw/rtl/dssd_pkg.sv
// ----------------------------------------------------------------------------
// Dual seven-segment driver package
// Command codes, register indexes, the segment table and the stage structs.
// ----------------------------------------------------------------------------
package dssd_pkg;

  localparam int PAT_DEPTH = 256;
  localparam int PAT_AW    = 8;

  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 40;

  typedef enum logic [2:0] {
    CMD_SET  = 3'd0,
    CMD_INC  = 3'd1,
    CMD_DEC  = 3'd2,
    CMD_SHOW = 3'd3,
    CMD_NEXT = 3'd4,
    CMD_PREV = 3'd5,
    CMD_LOAD = 3'd6,
    CMD_NOP  = 3'd7
  } cmd_t;

  localparam logic [1:0] MODE_OFF = 2'd0;
  localparam logic [1:0] MODE_DEC = 2'd1;
  localparam logic [1:0] MODE_HEX = 2'd2;
  localparam logic [1:0] MODE_PAT = 2'd3;

  localparam logic [1:0] REG_MODE      = 2'd0;
  localparam logic [1:0] REG_COUNT     = 2'd1;
  localparam logic [1:0] REG_ACTIVE_LO = 2'd2;

  localparam logic [7:0] DEC_MAX   = 8'd99;
  localparam logic [7:0] DEC_LIMIT = 8'd100;

  // Source of the displayed word once a command retires
  typedef enum logic [1:0] {
    SRC_KEEP = 2'd0,
    SRC_NUM  = 2'd1,
    SRC_MEM  = 2'd2
  } word_src_t;

  typedef struct packed {
    logic [1:0] mode;
    logic [7:0] count;
    logic       active_low;
    logic       mode_wr;
    logic       count_wr;
  } cfg_t;

  typedef struct packed {
    word_src_t   src;
    logic [15:0] num_word;
    logic [7:0]  value;
    logic [7:0]  index;
    logic        accepted;
  } stage_t;

  // gfedcba, segment a in bit 0
  function automatic logic [7:0] hex_seg(input logic [3:0] d);
    logic [7:0] s;
    case (d)
      4'h0: s = 8'h3F;
      4'h1: s = 8'h06;
      4'h2: s = 8'h5B;
      4'h3: s = 8'h4F;
      4'h4: s = 8'h66;
      4'h5: s = 8'h6D;
      4'h6: s = 8'h7D;
      4'h7: s = 8'h07;
      4'h8: s = 8'h7F;
      4'h9: s = 8'h6F;
      4'hA: s = 8'h77;
      4'hB: s = 8'h7C;
      4'hC: s = 8'h39;
      4'hD: s = 8'h5E;
      4'hE: s = 8'h79;
      4'hF: s = 8'h71;
      default: s = 8'h00;
    endcase
    return s;
  endfunction

  localparam logic [15:0] WORD_ZERO = 16'h3F3F;

  // Tens by reciprocal: (v * 205) >> 11 is exact for v below 1024
  function automatic logic [15:0] dec_word(input logic [7:0] v);
    logic [15:0] prod;
    logic [3:0]  tens;
    logic [7:0]  units;
    prod  = 16'(v) * 16'd205;
    tens  = 4'(prod >> 11);
    units = v - {4'd0, tens} * 8'd10;
    return {hex_seg(tens), hex_seg(units[3:0])};
  endfunction

  function automatic logic [15:0] hex_word(input logic [7:0] v);
    return {hex_seg(v[7:4]), hex_seg(v[3:0])};
  endfunction

endpackage

### hw/rtl/dual_seven_segment_display_driver.sv
// ----------------------------------------------------------------------------
// Dual seven-segment display driver
// Two-digit decimal, hexadecimal or pattern display with command stream.
// ----------------------------------------------------------------------------
// One command enters on the in_ stream and yields exactly one result on the
// out_ stream: both segment bytes after polarity, the stored value, the
// carousel index (zero outside pattern mode) and an accepted flag.
// An input transfer passes the command stage, then the output register, on
// its way to out_tvalid. One command is taken per cycle while out_tready is
// high; the command stage feeds one registered read of the 256-entry store.
// The cfg_ port writes display mode, pattern count and polarity. It is
// always ready; write only while no command is in flight.
// Reset (synchronous, rst_n low) clears the registers, value, index and
// display; the pattern store holds no defined data until loaded.
// When out_tready is low, the result holds and one more command is taken
// into the command stage before in_tready drops.
// ----------------------------------------------------------------------------
module dual_seven_segment_display_driver
  import dssd_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  // tdata: cmd[2:0], new_value[10:3], entry_index[18:11], entry_pattern[34:19]
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // tdata: left_segments[7:0], right_segments[15:8], current_value[23:16],
  //        current_index[31:24], accepted[32]
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [1:0]            cfg_index,
  input  logic [7:0]            cfg_data
);

  logic [1:0] mode_r;
  logic [7:0] count_r;
  logic       active_low_r;
  logic       cfg_wr;
  cfg_t       cfg;
  logic       stg_valid, stg_ready;
  stage_t     stg;
  logic [15:0] mem_rdata;

  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && cfg_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r       <= MODE_OFF;
      count_r      <= 8'd0;
      active_low_r <= 1'b0;
    end else if (cfg_wr) begin
      case (cfg_index)
        REG_MODE: begin
          mode_r <= cfg_data[1:0];
          if (cfg_data[1:0] == MODE_OFF) begin
            count_r <= 8'd0;
          end
        end
        REG_COUNT:     count_r      <= cfg_data;
        REG_ACTIVE_LO: active_low_r <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    cfg.mode       = mode_r;
    cfg.count      = count_r;
    cfg.active_low = active_low_r;
    cfg.mode_wr    = cfg_wr && cfg_index == REG_MODE;
    cfg.count_wr   = cfg_wr && cfg_index == REG_COUNT;
    if (cfg.mode_wr) begin
      cfg.mode = cfg_data[1:0];
    end
  end

  dssd_cmd u_cmd (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .nxt_ready (stg_ready),
    .stg_valid (stg_valid),
    .stg       (stg),
    .mem_rdata (mem_rdata)
  );

  dssd_out u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .stg_valid  (stg_valid),
    .stg        (stg),
    .mem_rdata  (mem_rdata),
    .stg_ready  (stg_ready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

### hw/rtl/dssd_cmd.sv
// ----------------------------------------------------------------------------
// Command stage
// Decodes a command, updates value and carousel index, owns the pattern
// store and registers the decoded result for the output stage.
// ----------------------------------------------------------------------------
module dssd_cmd
  import dssd_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  cfg_t                  cfg,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,
  input  logic                  nxt_ready,
  output logic                  stg_valid,
  output stage_t                stg,
  output logic [15:0]           mem_rdata
);

  logic [15:0] mem [PAT_DEPTH];
  logic [15:0] rdata_r;

  logic [7:0]  number_value_r, number_value_nxt;
  logic [7:0]  carousel_index_r, carousel_index_nxt;
  logic        valid_r;
  stage_t      stg_r, stg_nxt;

  logic [2:0]  cmd;
  logic [7:0]  nv, idx;
  logic [15:0] pat;
  logic        accept, adv, mem_wr;
  logic        is_dec, is_hex, is_pat;
  logic [7:0]  inc_idx;
  logic [7:0]  num_v;
  logic        num_upd;

  assign cmd = in_tdata[2:0];
  assign nv  = in_tdata[10:3];
  assign idx = in_tdata[18:11];
  assign pat = in_tdata[34:19];

  assign adv       = valid_r && nxt_ready;
  assign in_tready = !valid_r || nxt_ready;
  assign accept    = in_tvalid && in_tready;

  assign is_dec = cfg.mode == MODE_DEC;
  assign is_hex = cfg.mode == MODE_HEX;
  assign is_pat = cfg.mode == MODE_PAT;

  assign inc_idx = carousel_index_r + 8'd1;

  always_comb begin
    number_value_nxt   = number_value_r;
    carousel_index_nxt = carousel_index_r;
    num_v              = number_value_r;
    num_upd            = 1'b0;
    mem_wr             = 1'b0;
    stg_nxt            = '0;
    stg_nxt.src        = SRC_KEEP;
    case (cmd)
      CMD_SET: begin
        num_v   = nv;
        num_upd = 1'b1;
      end
      CMD_INC: begin
        if (is_dec) begin
          if (number_value_r < DEC_MAX) begin
            num_v   = number_value_r + 8'd1;
            num_upd = 1'b1;
          end else if (number_value_r == DEC_MAX) begin
            num_v   = 8'd0;
            num_upd = 1'b1;
          end
        end else if (is_hex) begin
          num_v   = number_value_r + 8'd1;
          num_upd = 1'b1;
        end
      end
      CMD_DEC: begin
        if (is_dec) begin
          num_v   = (number_value_r == 8'd0) ? DEC_MAX : number_value_r - 8'd1;
          num_upd = 1'b1;
          stg_nxt.accepted = 1'b1;
        end else if (is_hex) begin
          num_v   = number_value_r - 8'd1;
          num_upd = 1'b1;
        end
      end
      CMD_SHOW: begin
        if (is_pat && idx < cfg.count) begin
          carousel_index_nxt = idx;
          stg_nxt.src        = SRC_MEM;
          stg_nxt.accepted   = 1'b1;
        end
      end
      CMD_NEXT: begin
        if (is_pat && cfg.count != 8'd0) begin
          carousel_index_nxt = (inc_idx >= cfg.count) ? 8'd0 : inc_idx;
          stg_nxt.src        = SRC_MEM;
          stg_nxt.accepted   = 1'b1;
        end
      end
      CMD_PREV: begin
        if (is_pat && cfg.count != 8'd0) begin
          carousel_index_nxt = (carousel_index_r == 8'd0) ? cfg.count - 8'd1
                                                          : carousel_index_r - 8'd1;
          stg_nxt.src        = SRC_MEM;
          stg_nxt.accepted   = 1'b1;
        end
      end
      CMD_LOAD: begin
        if ({1'b0, idx} < 9'(PAT_DEPTH)) begin
          mem_wr           = 1'b1;
          stg_nxt.accepted = 1'b1;
        end
      end
      default: begin
      end
    endcase

    if (num_upd) begin
      number_value_nxt = num_v;
      if (is_hex) begin
        stg_nxt.src      = SRC_NUM;
        stg_nxt.num_word = hex_word(num_v);
        stg_nxt.accepted = 1'b1;
      end else if (is_dec && num_v < DEC_LIMIT) begin
        stg_nxt.src      = SRC_NUM;
        stg_nxt.num_word = dec_word(num_v);
        stg_nxt.accepted = 1'b1;
      end
    end

    stg_nxt.value = number_value_nxt;
    stg_nxt.index = is_pat ? carousel_index_nxt : 8'd0;
  end

  always_ff @(posedge clk) begin
    if (accept && mem_wr) begin
      mem[idx[PAT_AW-1:0]] <= pat;
    end
    if (accept) begin
      rdata_r <= mem[carousel_index_nxt[PAT_AW-1:0]];
      stg_r   <= stg_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r          <= 1'b0;
      number_value_r   <= 8'd0;
      carousel_index_r <= 8'd0;
    end else begin
      if (accept) begin
        valid_r <= 1'b1;
      end else if (adv) begin
        valid_r <= 1'b0;
      end
      if (cfg.mode_wr && cfg.mode != MODE_PAT) begin
        number_value_r <= 8'd0;
      end else if (accept) begin
        number_value_r <= number_value_nxt;
      end
      if (cfg.count_wr || (cfg.mode_wr && cfg.mode == MODE_OFF)) begin
        carousel_index_r <= 8'd0;
      end else if (accept) begin
        carousel_index_r <= carousel_index_nxt;
      end
    end
  end

  assign stg_valid = valid_r;
  assign stg       = stg_r;
  assign mem_rdata = rdata_r;

endmodule

### hw/rtl/dssd_out.sv
// ----------------------------------------------------------------------------
// Output stage
// Resolves the displayed word, applies polarity and holds the result
// transfer until the receiver takes it.
// ----------------------------------------------------------------------------
module dssd_out
  import dssd_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  cfg_t                  cfg,
  input  logic                  stg_valid,
  input  stage_t                stg,
  input  logic [15:0]           mem_rdata,
  output logic                  stg_ready,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata
);

  logic [15:0]           shown_word_r, shown_nxt, drive;
  logic                  valid_r;
  logic [OUT_DATA_W-1:0] data_r;
  logic                  adv;

  assign stg_ready = !valid_r || out_tready;
  assign adv       = stg_valid && stg_ready;

  always_comb begin
    case (stg.src)
      SRC_NUM: shown_nxt = stg.num_word;
      SRC_MEM: shown_nxt = mem_rdata;
      default: shown_nxt = shown_word_r;
    endcase
    drive = shown_nxt ^ {16{cfg.active_low}};
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      data_r <= {7'd0, stg.accepted, stg.index, stg.value, drive[7:0], drive[15:8]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r      <= 1'b0;
      shown_word_r <= 16'd0;
    end else begin
      if (adv) begin
        valid_r <= 1'b1;
      end else if (out_tready) begin
        valid_r <= 1'b0;
      end
      if (cfg.mode_wr && cfg.mode == MODE_OFF) begin
        shown_word_r <= 16'd0;
      end else if (cfg.mode_wr && cfg.mode != MODE_PAT) begin
        shown_word_r <= WORD_ZERO;
      end else if (adv) begin
        shown_word_r <= shown_nxt;
      end
    end
  end

  assign out_tvalid = valid_r;
  assign out_tdata  = data_r;

endmodule

### test/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Dual seven-segment display driver testbench
// A directed table walks the value commands, the carousel and the register
// writes. Random command phases follow, each under a freshly written mode;
// count and polarity are rewritten at random. Results are checked against the
// table or a local display model, with random idle bursts on input and results.
// ----------------------------------------------------------------------------
module tb;
  import dssd_pkg::*;

  localparam logic [1:0] REG_SPARE = 2'd3;   // no register behind this index
  localparam int N_RANDOM    = 1050;
  localparam int CALM_TAIL   = 80;
  localparam int CYCLE_LIMIT = 400000;
  localparam int MAX_PRINTS  = 100;

  localparam logic [7:0] SEG_LUT [0:15] = '{
    8'h3F, 8'h06, 8'h5B, 8'h4F, 8'h66, 8'h6D, 8'h7D, 8'h07,
    8'h7F, 8'h6F, 8'h77, 8'h7C, 8'h39, 8'h5E, 8'h79, 8'h71
  };

  typedef struct packed {
    cmd_t        cmd;
    logic [7:0]  value;
    logic [7:0]  index;
    logic [15:0] pattern;
  } disp_cmd_t;

  typedef struct packed {
    logic [7:0] left;
    logic [7:0] right;
    logic [7:0] value;
    logic [7:0] index;
    logic       accepted;
  } disp_result_t;

  typedef struct packed {
    logic         is_reg;
    logic [1:0]   reg_idx;
    logic [7:0]   reg_val;
    disp_cmd_t    cmd;
    logic         typed;
    disp_result_t res;
  } stim_row_t;

  localparam disp_cmd_t    NO_CMD = '{CMD_NOP, 8'd0, 8'd0, 16'h0000};
  localparam disp_result_t NO_RES = '0;

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata   = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  cfg_valid  = 1'b0;
  logic                  cfg_ready;
  logic [1:0]            cfg_index  = '0;
  logic [7:0]            cfg_data   = '0;

  always #6 clk = ~clk;

  dual_seven_segment_display_driver dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  // Display state as the block should hold it
  logic [1:0]  mdl_mode;
  logic [7:0]  mdl_count;
  logic        mdl_active_lo;
  logic [7:0]  mdl_value;
  logic [15:0] mdl_word;
  logic [7:0]  mdl_index;
  logic [15:0] mdl_store [0:PAT_DEPTH-1];
  bit          loaded    [0:PAT_DEPTH-1];

  disp_result_t expected_displays [$];
  int           err_count   = 0;
  int           cycle_count = 0;
  int           random_sent = 0;
  bit           idle_on     = 1'b1;

  stim_row_t directed_rows [0:33] = '{
    '{1'b0, REG_MODE, 8'd0, '{CMD_LOAD, 8'd0, 8'd0, 16'h1234}, 1'b1,
      '{8'h00, 8'h00, 8'h00, 8'h00, 1'b1}},
    '{1'b0, REG_MODE, 8'd0, '{CMD_LOAD, 8'd0, 8'd255, 16'hFFFF}, 1'b1,
      '{8'h00, 8'h00, 8'h00, 8'h00, 1'b1}},
    '{1'b0, REG_MODE, 8'd0, '{CMD_LOAD, 8'd0, 8'd1, 16'h0000}, 1'b1,
      '{8'h00, 8'h00, 8'h00, 8'h00, 1'b1}},
    // value is stored while off but nothing is shown
    '{1'b0, REG_MODE, 8'd0, '{CMD_SET, 8'hFF, 8'd0, 16'h0000}, 1'b1,
      '{8'h00, 8'h00, 8'hFF, 8'h00, 1'b0}},
    '{1'b0, REG_MODE, 8'd0, '{CMD_INC, 8'd0, 8'd0, 16'h0000}, 1'b1,
      '{8'h00, 8'h00, 8'hFF, 8'h00, 1'b0}},
    '{1'b0, REG_MODE, 8'd0, '{CMD_NOP, 8'd0, 8'd0, 16'h0000}, 1'b1,
      '{8'h00, 8'h00, 8'hFF, 8'h00, 1'b0}},
    '{1'b1, REG_MODE, {6'd0, MODE_DEC}, NO_CMD, 1'b0, NO_RES},
    '{1'b0, REG_MODE, 8'd0, '{CMD_DEC, 8'd0, 8'd0, 16'h0000}, 1'b1,
      '{8'h6F, 8'h6F, 8'd99, 8'h00, 1'b1}},
    '{1'b0, REG_MODE, 8'd0, '{CMD_INC, 8'd0, 8'd0, 16'h0000}, 1'b1,
      '{8'h3F, 8'h3F, 8'd0, 8'h00, 1'b1}},
    '{1'b0, REG_MODE, 8'd0, '{CMD_SET, 8'd99, 8'd0, 16'h0000}, 1'b0, NO_RES},
    '{1'b0, REG_MODE, 8'd0, '{CMD_SET, 8'd100, 8'd0, 16'h0000}, 1'b0, NO_RES},
    '{1'b0, REG_MODE, 8'd0, '{CMD_INC, 8'd0, 8'd0, 16'h0000}, 1'b0, NO_RES},
    '{1'b0, REG_MODE, 8'd0, '{CMD_SET, 8'd255, 8'd0, 16'h0000}, 1'b0, NO_RES},
    '{1'b0, REG_MODE, 8'd0, '{CMD_DEC, 8'd0, 8'd0, 16'h0000}, 1'b0, NO_RES},
    '{1'b0, REG_MODE, 8'd0, '{CMD_SHOW, 8'd0, 8'd0, 16'h0000}, 1'b0, NO_RES},
    '{1'b1, REG_MODE, {6'd0, MODE_HEX}, NO_CMD, 1'b0, NO_RES},
    '{1'b0, REG_MODE, 8'd0, '{CMD_DEC, 8'd0, 8'd0, 16'h0000}, 1'b1,
      '{8'h71, 8'h71, 8'hFF, 8'h00, 1'b1}},
    '{1'b0, REG_MODE, 8'd0, '{CMD_INC, 8'd0, 8'd0, 16'h0000}, 1'b1,
      '{8'h3F, 8'h3F, 8'h00, 8'h00, 1'b1}},
    '{1'b0, REG_MODE, 8'd0, '{CMD_SET, 8'hA5, 8'd0, 16'h0000}, 1'b0, NO_RES},
    '{1'b1, REG_ACTIVE_LO, 8'd1, NO_CMD, 1'b0, NO_RES},
    '{1'b0, REG_MODE, 8'd0, '{CMD_NEXT, 8'd0, 8'd0, 16'h0000}, 1'b0, NO_RES},
    '{1'b1, REG_MODE, {6'd0, MODE_PAT}, NO_CMD, 1'b0, NO_RES},
    '{1'b1, REG_COUNT, 8'd2, NO_CMD, 1'b0, NO_RES},
    '{1'b0, REG_MODE, 8'd0, '{CMD_SHOW, 8'd0, 8'd1, 16'h0000}, 1'b0, NO_RES},
    '{1'b0, REG_MODE, 8'd0, '{CMD_SHOW, 8'd0, 8'd255, 16'h0000}, 1'b0, NO_RES},
    '{1'b0, REG_MODE, 8'd0, '{CMD_NEXT, 8'd0, 8'd0, 16'h0000}, 1'b0, NO_RES},
    '{1'b0, REG_MODE, 8'd0, '{CMD_PREV, 8'd0, 8'd0, 16'h0000}, 1'b0, NO_RES},
    '{1'b0, REG_MODE, 8'd0, '{CMD_PREV, 8'd0, 8'd0, 16'h0000}, 1'b0, NO_RES},
    '{1'b1, REG_COUNT, 8'd0, NO_CMD, 1'b0, NO_RES},
    '{1'b0, REG_MODE, 8'd0, '{CMD_NEXT, 8'd0, 8'd0, 16'h0000}, 1'b0, NO_RES},
    '{1'b1, REG_ACTIVE_LO, 8'd0, NO_CMD, 1'b0, NO_RES},
    '{1'b1, REG_SPARE, 8'hFF, NO_CMD, 1'b0, NO_RES},
    '{1'b1, REG_MODE, {6'd0, MODE_OFF}, NO_CMD, 1'b0, NO_RES},
    '{1'b0, REG_MODE, 8'd0, '{CMD_PREV, 8'd0, 8'd0, 16'h0000}, 1'b0, NO_RES}
  };

  // Stores the value and redraws the digits where the mode allows
  function automatic bit refresh_number(input logic [7:0] v);
    mdl_value = v;
    if (mdl_mode == MODE_DEC && v < DEC_LIMIT) begin
      mdl_word = {SEG_LUT[v / 10], SEG_LUT[v % 10]};
      return 1'b1;
    end
    if (mdl_mode == MODE_HEX) begin
      mdl_word = {SEG_LUT[v[7:4]], SEG_LUT[v[3:0]]};
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic void apply_reg(input logic [1:0] idx, input logic [7:0] val);
    case (idx)
      REG_MODE: begin
        mdl_mode = val[1:0];
        if (mdl_mode == MODE_OFF) begin
          mdl_value = '0;
          mdl_word  = '0;
          mdl_index = '0;
          mdl_count = '0;
        end else if (mdl_mode == MODE_DEC || mdl_mode == MODE_HEX) begin
          void'(refresh_number(8'd0));
        end
      end
      REG_COUNT: begin
        mdl_count = val;
        mdl_index = '0;
      end
      REG_ACTIVE_LO: mdl_active_lo = val[0];
      default: ;
    endcase
  endfunction

  function automatic disp_result_t predict_display(input disp_cmd_t c);
    logic         acc;
    logic [15:0]  w;
    bit           pat_mode;
    disp_result_t r;
    acc      = 1'b0;
    pat_mode = (mdl_mode == MODE_PAT);
    case (c.cmd)
      CMD_SET: acc = refresh_number(c.value);
      CMD_INC: begin
        if (mdl_mode == MODE_DEC) begin
          // at 100 and above the increment is refused
          if (mdl_value < DEC_MAX) begin
            void'(refresh_number(mdl_value + 8'd1));
            acc = 1'b1;
          end else if (mdl_value == DEC_MAX) begin
            void'(refresh_number(8'd0));
            acc = 1'b1;
          end
        end else if (mdl_mode == MODE_HEX) begin
          void'(refresh_number(mdl_value + 8'd1));
          acc = 1'b1;
        end
      end
      CMD_DEC: begin
        if (mdl_mode == MODE_DEC) begin
          void'(refresh_number(mdl_value == 8'd0 ? DEC_MAX : mdl_value - 8'd1));
          acc = 1'b1;
        end else if (mdl_mode == MODE_HEX) begin
          void'(refresh_number(mdl_value - 8'd1));
          acc = 1'b1;
        end
      end
      CMD_SHOW: begin
        if (pat_mode && c.index < mdl_count) begin
          mdl_index = c.index;
          mdl_word  = mdl_store[c.index];
          acc       = 1'b1;
        end
      end
      CMD_NEXT: begin
        if (pat_mode && mdl_count != 8'd0) begin
          mdl_index = mdl_index + 8'd1;
          if (mdl_index >= mdl_count) mdl_index = '0;
          mdl_word = mdl_store[mdl_index];
          acc      = 1'b1;
        end
      end
      CMD_PREV: begin
        if (pat_mode && mdl_count != 8'd0) begin
          mdl_index = (mdl_index == 8'd0) ? mdl_count - 8'd1 : mdl_index - 8'd1;
          mdl_word  = mdl_store[mdl_index];
          acc       = 1'b1;
        end
      end
      CMD_LOAD: begin
        mdl_store[c.index] = c.pattern;
        loaded[c.index]    = 1'b1;
        acc                = 1'b1;
      end
      default: ;
    endcase
    w          = mdl_active_lo ? ~mdl_word : mdl_word;
    r.left     = w[15:8];
    r.right    = w[7:0];
    r.value    = mdl_value;
    r.index    = pat_mode ? mdl_index : 8'd0;
    r.accepted = acc;
    return r;
  endfunction

  // First loaded entry from start upward, wrapping past the top, so a show never reads an empty slot
  function automatic logic [7:0] loaded_index(input logic [7:0] start);
    for (int k = 0; k < PAT_DEPTH; k++) begin
      if (loaded[8'(start + k)]) return 8'(start + k);
    end
    return 8'd0;
  endfunction

  function automatic disp_cmd_t random_cmd();
    disp_cmd_t c;
    int        r;
    c.cmd     = CMD_NOP;
    c.value   = 8'($urandom);
    c.index   = 8'($urandom);
    c.pattern = 16'($urandom);
    r         = $urandom_range(0, 99);
    if (r < 12 || mdl_mode == MODE_OFF) begin
      c.cmd = cmd_t'($urandom_range(0, 7));
    end else if (mdl_mode == MODE_PAT) begin
      case ($urandom_range(0, 3))
        0:       c.cmd = CMD_SHOW;
        1:       c.cmd = CMD_NEXT;
        2:       c.cmd = CMD_PREV;
        default: c.cmd = CMD_LOAD;
      endcase
      if ($urandom_range(0, 1)) c.index = 8'($urandom_range(0, mdl_count));
    end else begin
      case ($urandom_range(0, 3))
        0:       c.cmd = CMD_SET;
        1:       c.cmd = CMD_INC;
        2:       c.cmd = CMD_DEC;
        default: c.cmd = CMD_INC;
      endcase
      // decimal: stay mostly in range, sometimes cross the 100 boundary
      if (mdl_mode == MODE_DEC) begin
        case ($urandom_range(0, 3))
          0:       ;
          1:       c.value = 8'($urandom_range(95, 105));
          default: c.value = 8'($urandom_range(0, 99));
        endcase
      end
    end
    if (c.cmd == CMD_SHOW) c.index = loaded_index(c.index);
    return c;
  endfunction

  task automatic report(input string what, input logic [7:0] got, input logic [7:0] want);
    if (err_count < MAX_PRINTS)
      $display("%0t ns: %s got %02h expected %02h", $realtime, what, got, want);
    err_count++;
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (expected_displays.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
    drain();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    apply_reg(idx, val);
  endtask

  task automatic send_cmd(input disp_cmd_t c, input logic typed, input disp_result_t typed_res);
    disp_result_t r;
    if (idle_on && $urandom_range(0, 7) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= IN_DATA_W'({c.pattern, c.index, c.value, c.cmd});
    do @(posedge clk); while (!in_tready);
    r = predict_display(c);
    expected_displays.push_back(typed ? typed_res : r);
  endtask

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("dual_seven_segment_display_driver: mismatch");
      $finish;
    end
  end

  initial begin : result_sink
    int           stall;
    disp_result_t got;
    disp_result_t want;
    stall = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_tvalid && out_tready) begin
        got.left     = out_tdata[7:0];
        got.right    = out_tdata[15:8];
        got.value    = out_tdata[23:16];
        got.index    = out_tdata[31:24];
        got.accepted = out_tdata[32];
        if (expected_displays.size() == 0) begin
          report("transfer with nothing pending", 8'd0, 8'd0);
        end else begin
          want = expected_displays.pop_front();
          if (got.left !== want.left) report("left_segments", got.left, want.left);
          if (got.right !== want.right) report("right_segments", got.right, want.right);
          if (got.value !== want.value) report("current_value", got.value, want.value);
          if (got.index !== want.index) report("current_index", got.index, want.index);
          if (got.accepted !== want.accepted)
            report("accepted", 8'(got.accepted), 8'(want.accepted));
        end
      end
      if (!idle_on) stall = 0;
      else if (stall > 0) stall--;
      else if ($urandom_range(0, 9) == 0) stall = $urandom_range(1, 19);
      out_tready <= (stall == 0);
    end
  end

  initial begin : stimulus
    stim_row_t  row;
    disp_cmd_t  c;
    logic [1:0] mode;
    int         phase_len;
    int         r;
    mdl_mode      = MODE_OFF;
    mdl_count     = '0;
    mdl_active_lo = 1'b0;
    mdl_value     = '0;
    mdl_word      = '0;
    mdl_index     = '0;
    for (int i = 0; i < PAT_DEPTH; i++) begin
      mdl_store[i] = '0;
      loaded[i]    = 1'b0;
    end

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      if (row.is_reg) write_reg(row.reg_idx, row.reg_val);
      else send_cmd(row.cmd, row.typed, row.res);
    end

    while (random_sent < N_RANDOM) begin
      idle_on = (random_sent < N_RANDOM - CALM_TAIL) && ($urandom_range(0, 3) != 0);
      mode    = 2'($urandom_range(0, 3));
      write_reg(REG_MODE, {6'd0, mode});
      if ($urandom_range(0, 9) < 7) begin
        r = $urandom_range(0, 9);
        write_reg(REG_COUNT, r == 0 ? 8'd0 :
                             r == 1 ? 8'd255 :
                             r == 2 ? 8'($urandom_range(100, 254)) :
                                      8'($urandom_range(1, 12)));
      end
      if ($urandom_range(0, 1)) write_reg(REG_ACTIVE_LO, {7'd0, 1'($urandom_range(0, 1))});
      if ($urandom_range(0, 9) == 0) write_reg(REG_SPARE, 8'($urandom));
      // carousel can land on any entry below the count, so fill those first
      for (int e = 0; e < mdl_count; e++) begin
        if (!loaded[e]) begin
          c = '{CMD_LOAD, 8'($urandom), 8'(e), 16'($urandom)};
          send_cmd(c, 1'b0, NO_RES);
          random_sent++;
        end
      end
      phase_len = $urandom_range(10, 60);
      for (int n = 0; n < phase_len && random_sent < N_RANDOM; n++) begin
        c = random_cmd();
        send_cmd(c, 1'b0, NO_RES);
        random_sent++;
        if (random_sent >= N_RANDOM - CALM_TAIL) idle_on = 1'b0;
        if ($urandom_range(0, 49) == 0) drain();
      end
    end

    drain();
    repeat (10) @(posedge clk);
    if (err_count == 0) begin
      $display("dual_seven_segment_display_driver: match");
    end else begin
      $display("dual_seven_segment_display_driver: mismatch");
    end
    $finish;
  end

endmodule

### files.f
hw/rtl/dssd_pkg.sv
hw/rtl/dssd_cmd.sv
hw/rtl/dssd_out.sv
hw/rtl/dual_seven_segment_display_driver.sv
test/tb.sv
